@@ rtl/tyuv_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tyuv_pkg
// Shared types, constants and helpers for the tiled YUV 4:2:0 to RGBA core.
// ============================================================================
package tyuv_pkg;

  // Register map: word index taken from paddr[2].
  localparam int unsigned CFG_ADDR_W       = 3;
  localparam logic        REG_IMAGE_WIDTH  = 1'b0;
  localparam logic        REG_UV_WIDTH     = 1'b1;

  localparam int unsigned IMG_W_BITS    = 11;
  localparam int unsigned CHROMA_W_BITS = 10;
  localparam logic [IMG_W_BITS-1:0]    IMAGE_WIDTH_RST  = 11'd640;
  localparam logic [CHROMA_W_BITS-1:0] UV_WIDTH_RST     = 10'd320;

  localparam int unsigned LUMA_OFS_W   = 20;
  localparam int unsigned CHROMA_OFS_W = 18;

  // BT.601 integer coefficients.
  localparam logic [7:0]         LUMA_BLACK = 8'd16;
  localparam logic signed [18:0] COEF_Y     = 19'sd298;
  localparam logic signed [18:0] COEF_RV    = 19'sd409;
  localparam logic signed [18:0] COEF_GU    = 19'sd100;
  localparam logic signed [18:0] COEF_GV    = 19'sd208;
  localparam logic signed [18:0] COEF_BU    = 19'sd516;
  localparam logic signed [18:0] ROUND_HALF = 19'sd128;
  localparam logic [7:0]         ALPHA_BYTE = 8'hff;

  // Load strobes for the three pipeline stages.
  typedef struct packed {
    logic ld1;
    logic ld2;
    logic ld3;
  } stage_en_t;

  // Floor divide by 256 and saturate to a byte.
  function automatic logic [7:0] clamp_byte(input logic signed [18:0] sum);
    logic [7:0] res;
    if (sum[18]) begin
      res = 8'd0;
    end else if (|sum[17:16]) begin
      res = 8'hff;
    end else begin
      res = sum[15:8];
    end
    return res;
  endfunction

endpackage

@@ rtl/tyuv_addr_pipe.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tyuv_addr_pipe
// Three-stage tiled offset generator for both luma samples and the chroma
// sample of one pixel pair.
// ============================================================================
module tyuv_addr_pipe import tyuv_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  stage_en_t                en,
  input  logic [IMG_W_BITS-1:0]    image_width,
  input  logic [CHROMA_W_BITS-1:0] uv_width,
  input  logic [9:0]               pixel_x,
  input  logic [9:0]               pixel_y,
  output logic [LUMA_OFS_W-1:0]    luma_offset_first,
  output logic [LUMA_OFS_W-1:0]    luma_offset_second,
  output logic [CHROMA_OFS_W-1:0]  chroma_offset,
  output logic                     second_valid
);

  // Stage 1 signals.
  logic [11:0] luma_ceil;
  logic [10:0] chroma_ceil;
  logic [10:0] x1;
  logic [16:0] lrow_nxt;
  logic [14:0] crow_nxt;
  logic [16:0] lrow_r;
  logic [14:0] crow_r;
  logic [9:0]  x_r;
  logic [10:0] x1_r;
  logic [2:0]  ylo_r;
  logic        sec1_r;

  // Stage 2 signals.
  logic [16:0] ltile0;
  logic [16:0] ltile1;
  logic [14:0] ctile;
  logic [LUMA_OFS_W-1:0]   lofs0_r;
  logic [LUMA_OFS_W-1:0]   lofs1_r;
  logic [CHROMA_OFS_W-1:0] cofs_r;
  logic                    sec2_r;

  always_comb begin
    luma_ceil   = {1'b0, image_width} + 12'd7;
    chroma_ceil = {1'b0, uv_width} + 11'd7;
    x1          = {1'b0, pixel_x} + 11'd1;
    lrow_nxt    = {9'd0, pixel_y[9:2]} * {8'd0, luma_ceil[11:3]};
    crow_nxt    = {8'd0, pixel_y[9:3]} * {7'd0, chroma_ceil[10:3]};
  end

  always_ff @(posedge clk) begin
    if (en.ld1) begin
      lrow_r <= lrow_nxt;
      crow_r <= crow_nxt;
      x_r    <= pixel_x;
      x1_r   <= x1;
      ylo_r  <= pixel_y[2:0];
      sec1_r <= x1 < image_width;
    end
  end

  always_comb begin
    ltile0 = lrow_r + {10'd0, x_r[9:3]};
    ltile1 = lrow_r + {9'd0, x1_r[10:3]};
    ctile  = crow_r + {9'd0, x_r[9:4]};
  end

  // Offset within a tile is row * 8 + column, always below 32, so it fills
  // the low five bits below the tile number.
  always_ff @(posedge clk) begin
    if (en.ld2) begin
      lofs0_r <= {ltile0[14:0], ylo_r[1:0], x_r[2:0]};
      lofs1_r <= {ltile1[14:0], ylo_r[1:0], x1_r[2:0]};
      cofs_r  <= {ctile[12:0], ylo_r[2:1], x_r[3:1]};
      sec2_r  <= sec1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      second_valid <= 1'b0;
    end else if (en.ld3) begin
      second_valid <= sec2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en.ld3) begin
      luma_offset_first  <= lofs0_r;
      luma_offset_second <= sec2_r ? lofs1_r : '0;
      chroma_offset      <= cofs_r;
    end
  end

endmodule

@@ rtl/tiled_yuv420_to_rgba_core.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tiled_yuv420_to_rgba_core
// Tiled YUV 4:2:0 pixel pair to RGBA converter with tiled offset generation.
// ============================================================================
// Each input transaction names a horizontal pixel pair and carries its two
// luma bytes and the shared U and V bytes. The core returns one output
// transaction per input: the tiled byte offsets (8x4 tiles of 32 bytes) of
// both luma samples and of the chroma sample, two RGBA words from integer
// BT.601 (red in the low byte, alpha 0xff in the top byte), and a flag that
// says whether the second pixel lies inside the configured image width; when
// it does not, the second offset and second color read as zero. The core is a
// three-stage pipeline (products, sums, clamp and pack) and accepts one
// transaction every clock cycle unless a stall on the result side holds it back.
// Each stage holds its data while the stage after it is full and stalled, so
// bubbles are squeezed out and input is taken even while a result waits.
// image_width (address 0x0) and uv_width (address 0x4) are written over
// the APB port and must only change while the pipeline is empty.
module tiled_yuv420_to_rgba_core import tyuv_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  // Configuration port.
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [CFG_ADDR_W-1:0]   paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  // Input channel.
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [9:0]              in_pixel_x,
  input  logic [9:0]              in_pixel_y,
  input  logic [7:0]              in_luma_first,
  input  logic [7:0]              in_luma_second,
  input  logic [7:0]              in_chroma_blue,
  input  logic [7:0]              in_chroma_red,
  // Result channel.
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [LUMA_OFS_W-1:0]   out_luma_offset_first,
  output logic [LUMA_OFS_W-1:0]   out_luma_offset_second,
  output logic [CHROMA_OFS_W-1:0] out_chroma_offset,
  output logic [31:0]             out_color_first,
  output logic [31:0]             out_color_second,
  output logic                    out_second_valid
);

  // --------------------------------------------------------------------------
  // Configuration registers.
  // --------------------------------------------------------------------------
  logic [IMG_W_BITS-1:0]    image_width_r;
  logic [CHROMA_W_BITS-1:0] uv_width_r;
  logic                     cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r <= IMAGE_WIDTH_RST;
      uv_width_r    <= UV_WIDTH_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_IMAGE_WIDTH: image_width_r <= pwdata[IMG_W_BITS-1:0];
        REG_UV_WIDTH:    uv_width_r    <= pwdata[CHROMA_W_BITS-1:0];
        default:         image_width_r <= image_width_r;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_IMAGE_WIDTH: prdata = {{(32-IMG_W_BITS){1'b0}}, image_width_r};
      REG_UV_WIDTH:    prdata = {{(32-CHROMA_W_BITS){1'b0}}, uv_width_r};
      default:         prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Pipeline control. A stage may load when it is empty or when the stage
  // after it is loading too; valid bits travel with the data.
  // --------------------------------------------------------------------------
  logic      v1_r, v2_r, v3_r;
  logic      rdy1, rdy2, rdy3;
  stage_en_t en;

  always_comb begin
    rdy3   = !v3_r || out_ready;
    rdy2   = !v2_r || rdy3;
    rdy1   = !v1_r || rdy2;
    en.ld1 = rdy1 && in_valid;
    en.ld2 = rdy2 && v1_r;
    en.ld3 = rdy3 && v2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= in_valid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
    end
  end

  assign in_ready  = rdy1;
  assign out_valid = v3_r;

  // --------------------------------------------------------------------------
  // Address path.
  // --------------------------------------------------------------------------
  tyuv_addr_pipe u_addr (
    .clk                (clk),
    .rst_n              (rst_n),
    .en                 (en),
    .image_width        (image_width_r),
    .uv_width           (uv_width_r),
    .pixel_x            (in_pixel_x),
    .pixel_y            (in_pixel_y),
    .luma_offset_first  (out_luma_offset_first),
    .luma_offset_second (out_luma_offset_second),
    .chroma_offset      (out_chroma_offset),
    .second_valid       (out_second_valid)
  );

  // --------------------------------------------------------------------------
  // Color path, stage 1: clip luma at black level and form every product.
  // U and V minus 128 is simply the byte with its top bit flipped, read as
  // a signed value.
  // --------------------------------------------------------------------------
  logic [7:0]         l0, l1;
  logic signed [18:0] cu, cv;
  logic [16:0]        y0p_nxt, y1p_nxt;
  logic [16:0]        y0p_r, y1p_r;
  logic signed [16:0] prv_r;
  logic signed [14:0] pgu_r;
  logic signed [15:0] pgv_r;
  logic signed [17:0] pbu_r;
  logic signed [18:0] prv_nxt, pgu_nxt, pgv_nxt, pbu_nxt;
  logic signed [18:0] y0m, y1m;

  always_comb begin
    l0      = (in_luma_first > LUMA_BLACK) ? in_luma_first - LUMA_BLACK : 8'd0;
    l1      = (in_luma_second > LUMA_BLACK) ? in_luma_second - LUMA_BLACK : 8'd0;
    cu      = 19'($signed({~in_chroma_blue[7], in_chroma_blue[6:0]}));
    cv      = 19'($signed({~in_chroma_red[7], in_chroma_red[6:0]}));
    y0m     = $signed({11'd0, l0}) * COEF_Y;
    y1m     = $signed({11'd0, l1}) * COEF_Y;
    y0p_nxt = y0m[16:0];
    y1p_nxt = y1m[16:0];
    prv_nxt = cv * COEF_RV;
    pgu_nxt = cu * COEF_GU;
    pgv_nxt = cv * COEF_GV;
    pbu_nxt = cu * COEF_BU;
  end

  always_ff @(posedge clk) begin
    if (en.ld1) begin
      y0p_r <= y0p_nxt;
      y1p_r <= y1p_nxt;
      prv_r <= prv_nxt[16:0];
      pgu_r <= pgu_nxt[14:0];
      pgv_r <= pgv_nxt[15:0];
      pbu_r <= pbu_nxt[17:0];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: the three channel sums for each pixel.
  // --------------------------------------------------------------------------
  logic signed [18:0] yc0, yc1;
  logic signed [18:0] r0_r, g0_r, b0_r, r1_r, g1_r, b1_r;

  always_comb begin
    yc0 = $signed({2'b00, y0p_r}) + ROUND_HALF;
    yc1 = $signed({2'b00, y1p_r}) + ROUND_HALF;
  end

  always_ff @(posedge clk) begin
    if (en.ld2) begin
      r0_r <= yc0 + 19'(prv_r);
      g0_r <= yc0 - 19'(pgu_r) - 19'(pgv_r);
      b0_r <= yc0 + 19'(pbu_r);
      r1_r <= yc1 + 19'(prv_r);
      g1_r <= yc1 - 19'(pgu_r) - 19'(pgv_r);
      b1_r <= yc1 + 19'(pbu_r);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: shift, clamp and pack into the output register. The second word
  // is zeroed after that register when the second pixel falls outside the image.
  // --------------------------------------------------------------------------
  logic [31:0] color0_r, color1_r;

  always_ff @(posedge clk) begin
    if (en.ld3) begin
      color0_r <= {ALPHA_BYTE, clamp_byte(b0_r), clamp_byte(g0_r), clamp_byte(r0_r)};
      color1_r <= {ALPHA_BYTE, clamp_byte(b1_r), clamp_byte(g1_r), clamp_byte(r1_r)};
    end
  end

  assign out_color_first  = color0_r;
  assign out_color_second = out_second_valid ? color1_r : 32'd0;

endmodule

@@ rtl/tyuv_checker.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tyuv_checker
// Port-level checks for the tiled YUV 4:2:0 to RGBA core, bound to the top.
// ============================================================================
module tyuv_checker import tyuv_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [LUMA_OFS_W-1:0]   out_luma_offset_first,
  input logic [LUMA_OFS_W-1:0]   out_luma_offset_second,
  input logic [31:0]             out_color_first,
  input logic [31:0]             out_color_second,
  input logic                    out_second_valid
);

  // A stalled result keeps its first color and first luma offset.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_color_first)
      && $stable(out_luma_offset_first))
    else $error("result changed while stalled");

  // A pair whose second pixel is outside the image reports zeros for it.
  a_second_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_second_valid |->
      out_color_second == 32'd0 && out_luma_offset_second == '0)
    else $error("second pixel fields not zero");

  // Alpha is always opaque on every valid word.
  a_alpha: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_color_first[31:24] == ALPHA_BYTE
      && (!out_second_valid || out_color_second[31:24] == ALPHA_BYTE))
    else $error("alpha byte not opaque");

  // With the result side always ready, an accepted transaction shows up
  // as a valid result once it has passed the stage registers.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && out_ready ##1 out_ready ##1 out_ready |=> out_valid)
    else $error("result missing after pipeline latency");

endmodule

bind tiled_yuv420_to_rgba_core tyuv_checker u_tyuv_checker (.*);
